/* rtl/assert_macros.svh */
// assertion helper macros for the blit copy sequencer controller
// no dependencies; included by bcw_ctrl, the only file that carries assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/bcw_pkg.sv */
// shared types and constants for the blit copy write sequencer
// no dependencies
package bcw_pkg;

    localparam int ADDR_W  = 32;
    localparam int PITCH_W = 16;
    localparam int CALC_W  = 13;
    localparam int ROWS_W  = 12;
    localparam int PADDR_W = 4;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // engine register selects and values
    localparam logic [1:0] SEL_MODE  = 2'd0;
    localparam logic [1:0] SEL_ROP   = 2'd1;
    localparam logic [1:0] SEL_SHIFT = 2'd2;
    localparam logic [31:0] MODE_COPY = 32'd7;
    localparam logic [31:0] MODE_IDLE = 32'd0;
    localparam logic [31:0] ROP_COPY  = 32'd3;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_ROW   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SRC_BASE  = 2'd0;
    localparam logic [1:0] CFG_DST_BASE  = 2'd1;
    localparam logic [1:0] CFG_SRC_PITCH = 2'd2;
    localparam logic [1:0] CFG_DST_PITCH = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_REGW, S_ROW, S_REST, S_ERR
    } t_state;

    typedef enum logic [3:0] {
        RES_NONE, RES_MODE7, RES_OP, RES_SHIFT, RES_WORD,
        RES_SHIFT0, RES_MODE0, RES_OPCOPY, RES_ERR
    } t_res;

    typedef struct packed {
        logic load_start;
        logic load_row;
        logic word_adv;
        t_res res;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic more_words;
        logic last_row;
    } t_stat;

endpackage

/* rtl/bcw_regs.sv */
// configuration registers behind the apb-style port
// depends on bcw_pkg
module bcw_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcw_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [bcw_pkg::ADDR_W-1:0]      o_src_base,
    output logic [bcw_pkg::ADDR_W-1:0]      o_dst_base,
    output logic [bcw_pkg::PITCH_W-1:0]     o_src_pitch,
    output logic [bcw_pkg::PITCH_W-1:0]     o_dst_pitch
);
    import bcw_pkg::*;

    logic [ADDR_W-1:0]  r_src_base, r_dst_base;
    logic [PITCH_W-1:0] r_src_pitch, r_dst_pitch;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base  <= '0;
            r_dst_base  <= '0;
            r_src_pitch <= '0;
            r_dst_pitch <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                CFG_SRC_BASE:  r_src_base  <= pwdata;
                CFG_DST_BASE:  r_dst_base  <= pwdata;
                CFG_SRC_PITCH: r_src_pitch <= pwdata[PITCH_W-1:0];
                CFG_DST_PITCH: r_dst_pitch <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[3:2])
            CFG_SRC_BASE:  prdata = r_src_base;
            CFG_DST_BASE:  prdata = r_dst_base;
            CFG_SRC_PITCH: prdata = {16'd0, r_src_pitch};
            CFG_DST_PITCH: prdata = {16'd0, r_dst_pitch};
            default:       prdata = '0;
        endcase
    end

    assign o_src_base  = r_src_base;
    assign o_dst_base  = r_dst_base;
    assign o_src_pitch = r_src_pitch;
    assign o_dst_pitch = r_dst_pitch;

endmodule

/* rtl/bcw_ctrl.sv */
// sequencing state machine: picks which result goes out each cycle
// depends on bcw_pkg and assert_macros.svh
`include "assert_macros.svh"
module bcw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_req_type,
    input  bcw_pkg::t_stat  i_stat,
    output logic            o_busy,
    output bcw_pkg::t_cmd   o_cmd
);
    import bcw_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '{load_start: 1'b0, load_row: 1'b0, word_adv: 1'b0,
                    res: RES_NONE, last: 1'b0};
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (i_req_type == REQ_START) begin
                        o_cmd.load_start = 1'b1;
                        n_state = S_REGW;
                    end else if (i_stat.active) begin
                        o_cmd.load_row = 1'b1;
                        n_state = S_ROW;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_REGW: begin
                n_idx = r_idx + 2'd1;
                case (r_idx)
                    2'd0:    o_cmd.res = RES_MODE7;
                    2'd1:    o_cmd.res = RES_OP;
                    default: begin
                        o_cmd.res  = RES_SHIFT;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_ROW: begin
                o_cmd.res      = RES_WORD;
                o_cmd.word_adv = 1'b1;
                n_idx          = '0;
                if (!i_stat.more_words) begin
                    if (i_stat.last_row) begin
                        n_state = S_REST;
                    end else begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_REST: begin
                n_idx = r_idx + 2'd1;
                case (r_idx)
                    2'd0:    o_cmd.res = RES_SHIFT0;
                    2'd1:    o_cmd.res = RES_MODE0;
                    default: begin
                        o_cmd.res  = RES_OPCOPY;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_ERR: begin
                o_cmd.res  = RES_ERR;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_CLK(a_start_regw, i_clk, i_rst_n, (accept && i_req_type == REQ_START) |=> (r_state == S_REGW && r_idx == 2'd0), "start transfer must begin register writes")
    `ASSERT_NEVER(a_last_valid, i_clk, i_rst_n, o_cmd.last && o_cmd.res == RES_NONE, "last flag without result")
    `ASSERT_CLK(a_err_once, i_clk, i_rst_n, (r_state == S_ERR) |=> (r_state == S_IDLE), "error result must be single")

endmodule

/* rtl/bcw_dp.sv */
// datapath: copy setup math, row and word address generation, result mux
// depends on bcw_pkg
module bcw_dp #(
    parameter int MAX_WIDTH  = bcw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bcw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bcw_pkg::t_cmd                i_cmd,
    output bcw_pkg::t_stat               o_stat,
    input  logic [bcw_pkg::ADDR_W-1:0]   i_src_base,
    input  logic [bcw_pkg::ADDR_W-1:0]   i_dst_base,
    input  logic [bcw_pkg::PITCH_W-1:0]  i_src_pitch,
    input  logic [bcw_pkg::PITCH_W-1:0]  i_dst_pitch,
    input  logic [9:0]                   i_src_x,
    input  logic [9:0]                   i_src_y,
    input  logic [9:0]                   i_dst_x,
    input  logic [9:0]                   i_dst_y,
    input  logic [10:0]                  i_rect_width,
    input  logic [10:0]                  i_rect_height,
    input  logic                         i_x_backward,
    input  logic                         i_y_upward,
    input  logic [3:0]                   i_rop,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [1:0]                   o_reg_select,
    output logic signed [31:0]           o_reg_value,
    output logic [31:0]                  o_src_addr,
    output logic [31:0]                  o_dst_addr,
    output logic [31:0]                  o_dst_mask,
    output logic                         o_last,
    output logic                         o_error
);
    import bcw_pkg::*;

    // command state
    logic                      r_active, r_left, r_up, r_first;
    logic [ROWS_W-1:0]         r_rows;
    logic [ADDR_W-1:0]         r_srow, r_drow, r_scol, r_dcol, r_sa, r_da;
    logic [31:0]               r_fmask, r_lmask;
    logic signed [CALC_W-1:0]  r_span, r_ps, r_xl;
    logic [3:0]                r_op;

    // start setup values
    logic signed [CALC_W-1:0]  sx, dx, w, sd, dd, al, ps, t, rw;
    logic                      left;
    logic [4:0]                ex;
    logic [5:0]                exl;
    logic [7:0]                b;
    logic [31:0]               pre, post;
    logic [10:0]               h;
    logic [ROWS_W-1:0]         row_s, row_d;
    logic [ADDR_W-1:0]         srow0, drow0, step, spitch4, dpitch4;

    always_comb begin
        sx   = CALC_W'(i_src_x);
        dx   = CALC_W'(i_dst_x);
        w    = CALC_W'(i_rect_width);
        h    = i_rect_height;
        b    = '0;
        if (i_rect_width == '0) w = CALC_W'(1);
        if (int'(i_rect_width) > MAX_WIDTH) w = CALC_W'(MAX_WIDTH);
        if (i_rect_height == '0) h = 11'd1;
        if (int'(i_rect_height) > MAX_HEIGHT) h = 11'(MAX_HEIGHT);
        left = i_x_backward && (i_src_y == i_dst_y);
        if (left) begin
            sx = sx + w;
            dx = dx + w;
            w  = -w;
        end
        sd = sx & ~CALC_W'(7);
        dd = dx & ~CALC_W'(7);
        al = dx - dd;
        ps = al - (sx - sd);
        if (!left && ps < 0) begin
            ps = ps + CALC_W'(8);
            dd = dd - CALC_W'(8);
            al = al + CALC_W'(8);
        end else if (left && ps >= 0) begin
            ps = ps - CALC_W'(8);
            dd = dd + CALC_W'(8);
            al = al - CALC_W'(8);
        end
        t   = al + w;
        rw  = ((t < 0) ? -t : t) + (left ? CALC_W'(8) : CALC_W'(0));
        ex  = rw[4:0];
        exl = 6'd32 - {1'b0, ex};
        if (!left) begin
            pre  = 32'hffff_ffff << al[3:0];
            post = (ex != 5'd0) ? (32'hffff_ffff >> (6'd32 - {1'b0, ex})) : 32'd0;
            if (ex != 5'd0 && rw < CALC_W'(32)) begin
                pre  = pre & post;
                post = '0;
            end
        end else begin
            // first word mask, right edge of a backward copy
            if (al < 0) begin
                b   = 8'hff >> 4'(-al);
                pre = 32'hffff_0000 | {16'd0, b, 8'd0};
            end else begin
                b   = 8'hff >> 4'(CALC_W'(8) - al);
                pre = 32'hffff_ff00 | {24'd0, b};
            end
            // final word mask, left edge
            if (exl < 6'd8) begin
                b    = 8'hff << exl[2:0];
                post = {b, 24'hff_ffff};
            end else if (exl < 6'd16) begin
                b    = 8'hff << exl[2:0];
                post = {8'd0, b, 16'hffff};
            end else if (exl < 6'd24) begin
                b    = 8'hff << exl[2:0];
                post = {16'd0, b, 8'hff};
            end else begin
                b    = 8'hff << 4'(exl - 6'd24);
                post = {24'd0, b};
            end
            if (rw < CALC_W'(32)) begin
                pre  = pre & post;
                post = '0;
            end
        end
    end

    // first row and row offsets
    assign row_s   = i_y_upward ? ROWS_W'(i_src_y) + ROWS_W'(h) - ROWS_W'(1)
                                : ROWS_W'(i_src_y);
    assign row_d   = i_y_upward ? ROWS_W'(i_dst_y) + ROWS_W'(h) - ROWS_W'(1)
                                : ROWS_W'(i_dst_y);
    assign srow0   = ADDR_W'({28'(row_s) * 28'(i_src_pitch), 2'b00});
    assign drow0   = ADDR_W'({28'(row_d) * 28'(i_dst_pitch), 2'b00});
    assign spitch4 = ADDR_W'({i_src_pitch, 2'b00});
    assign dpitch4 = ADDR_W'({i_dst_pitch, 2'b00});
    assign step    = r_left ? -ADDR_W'(32) : ADDR_W'(32);

    // status to the controller
    assign o_stat.active     = r_active;
    assign o_stat.more_words = (r_xl > CALC_W'(32));
    assign o_stat.last_row   = (r_rows <= ROWS_W'(1));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rows   <= '0;
        end else if (i_cmd.load_start) begin
            r_active <= 1'b1;
            r_rows   <= ROWS_W'(h);
        end else if (i_cmd.word_adv && !o_stat.more_words) begin
            if (r_rows != '0) r_rows <= r_rows - ROWS_W'(1);
            if (o_stat.last_row) r_active <= 1'b0;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_left  <= left;
            r_up    <= i_y_upward;
            r_srow  <= srow0;
            r_drow  <= drow0;
            r_scol  <= ADDR_W'(sd);
            r_dcol  <= ADDR_W'(dd);
            r_span  <= rw;
            r_fmask <= pre;
            r_lmask <= post;
            r_ps    <= ps;
            r_op    <= i_rop;
        end
        if (i_cmd.load_row) begin
            r_sa    <= i_src_base + r_srow + r_scol;
            r_da    <= i_dst_base + r_drow + r_dcol;
            r_xl    <= r_span;
            r_first <= 1'b1;
        end
        if (i_cmd.word_adv) begin
            r_sa    <= r_sa + step;
            r_da    <= r_da + step;
            r_xl    <= r_xl - CALC_W'(32);
            r_first <= 1'b0;
            if (!o_stat.more_words) begin
                r_srow <= r_up ? r_srow - spitch4 : r_srow + spitch4;
                r_drow <= r_up ? r_drow - dpitch4 : r_drow + dpitch4;
            end
        end
    end

    // result fields
    always_comb begin
        o_valid      = (i_cmd.res != RES_NONE);
        o_kind       = 1'b0;
        o_reg_select = SEL_MODE;
        o_reg_value  = '0;
        o_src_addr   = '0;
        o_dst_addr   = '0;
        o_dst_mask   = '0;
        o_error      = 1'b0;
        o_last       = i_cmd.last;
        case (i_cmd.res)
            RES_MODE7: o_reg_value = MODE_COPY;
            RES_OP: begin
                o_reg_select = SEL_ROP;
                o_reg_value  = {28'd0, r_op};
            end
            RES_SHIFT: begin
                o_reg_select = SEL_SHIFT;
                o_reg_value  = 32'(r_ps);
            end
            RES_WORD: begin
                o_kind     = 1'b1;
                o_src_addr = r_sa;
                o_dst_addr = r_da;
                o_dst_mask = r_first ? r_fmask
                           : ((r_xl >= CALC_W'(32)) ? 32'hffff_ffff : r_lmask);
            end
            RES_SHIFT0: o_reg_select = SEL_SHIFT;
            RES_MODE0:  o_reg_value  = MODE_IDLE;
            RES_OPCOPY: begin
                o_reg_select = SEL_ROP;
                o_reg_value  = ROP_COPY;
            end
            RES_ERR:    o_error = 1'b1;
            default: ;
        endcase
    end

endmodule

/* rtl/blit_copy_write_sequencer_top.sv */
// Rectangle copy write sequencer. A start transfer (req_type 0) has the
// accept cycle, then three engine register writes on consecutive cycles.
// A row transfer (req_type 1) has the accept cycle, then one result per word
// of the row (1 to 33 words), plus 3 restore writes after the last row; an
// idle row request has the accept cycle, then an error result. One result
// leaves per cycle from the sequencing state machine, so the row word loop
// sets the rate. busy is high until the last result of a request has been
// shown; results carry o_valid for exactly one cycle and cannot be held off.
// depends on bcw_pkg, bcw_regs, bcw_ctrl, bcw_dp
module blit_copy_write_sequencer_top #(
    parameter int MAX_WIDTH  = bcw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bcw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [9:0]                   i_src_x,
    input  logic [9:0]                   i_src_y,
    input  logic [9:0]                   i_dst_x,
    input  logic [9:0]                   i_dst_y,
    input  logic [10:0]                  i_rect_width,
    input  logic [10:0]                  i_rect_height,
    input  logic                         i_x_backward,
    input  logic                         i_y_upward,
    input  logic [3:0]                   i_rop,
    output logic                         o_valid,
    output logic                         o_kind,
    output logic [1:0]                   o_reg_select,
    output logic signed [31:0]           o_reg_value,
    output logic [31:0]                  o_src_addr,
    output logic [31:0]                  o_dst_addr,
    output logic [31:0]                  o_dst_mask,
    output logic                         o_last,
    output logic                         o_error
);
    import bcw_pkg::*;

    logic [ADDR_W-1:0]  src_base, dst_base;
    logic [PITCH_W-1:0] src_pitch, dst_pitch;
    t_cmd               cmd;
    t_stat              stat;

    // configuration registers
    bcw_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_src_base(src_base), .o_dst_base(dst_base),
        .o_src_pitch(src_pitch), .o_dst_pitch(dst_pitch)
    );

    // sequencing controller
    bcw_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_req_type, .i_stat(stat),
        .o_busy(busy), .o_cmd(cmd)
    );

    // address and mask datapath
    bcw_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_src_base(src_base), .i_dst_base(dst_base),
        .i_src_pitch(src_pitch), .i_dst_pitch(dst_pitch),
        .i_src_x, .i_src_y, .i_dst_x, .i_dst_y, .i_rect_width, .i_rect_height,
        .i_x_backward, .i_y_upward, .i_rop,
        .o_valid, .o_kind, .o_reg_select, .o_reg_value, .o_src_addr, .o_dst_addr,
        .o_dst_mask, .o_last, .o_error
    );

endmodule
